// ===== hw/rtl/sprite_scanline_evaluator_macros.svh =====
// Assertion macros shared by the sprite scanline evaluator checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SPRITE_SCANLINE_EVALUATOR_MACROS_SVH
`define SPRITE_SCANLINE_EVALUATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sse_pkg.sv =====
// Package for the sprite scanline evaluator: constants, codes, types.
// No dependencies; imported by every module of the block.
package sse_pkg;

    localparam int DEF_SPRITE_ENTRIES = 64;
    localparam int DEF_SLOTS          = 8;

    localparam int BYTE_W      = 8;
    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int SLOT_W      = 3;
    localparam int ROW_W       = 4;
    localparam int ADDR_W      = 13;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;
    localparam int OUT_FIELD_W = 50;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // byte lanes of one attribute entry
    localparam logic [LANE_W-1:0] LANE_Y    = 2'd0;
    localparam logic [LANE_W-1:0] LANE_TILE = 2'd1;
    localparam logic [LANE_W-1:0] LANE_ATTR = 2'd2;
    localparam logic [LANE_W-1:0] LANE_X    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TALL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int ATTR_VFLIP_BIT = 7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic clear;
        logic wr;
        logic start;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic final_done;
    } t_stat;

    typedef struct packed {
        logic [BYTE_W-1:0] scanline;
        logic [BYTE_W-1:0] mem_data;
        logic [BYTE_W-1:0] mem_address;
    } t_in_data;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [BYTE_W-1:0]  tile;
        logic [BYTE_W-1:0]  attr;
        logic [BYTE_W-1:0]  x_pos;
        logic [ROW_W-1:0]   row;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               zero_hit;
        logic               last;
    } t_result;

endpackage

// ===== hw/rtl/sse_ctrl.sv =====
// Sequencer of the sprite scanline evaluator: clear pass, item intake, scan, final result.
// Depends on sse_pkg; drives sse_dp through t_cmd and reads t_stat.
module sse_ctrl
    import sse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  logic  i_s_op,
    output logic  o_s_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_valid && i_s_op == OP_EVAL) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) n_state = ST_FINAL;
            end
            ST_FINAL: begin
                if (i_stat.final_done) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_s_ready   = 1'b1;
                o_cmd.wr    = i_s_valid && i_s_op == OP_WRITE;
                o_cmd.start = i_s_valid && i_s_op == OP_EVAL;
            end
            ST_SCAN:  o_cmd.scan   = 1'b1;
            ST_FINAL: o_cmd.finish = 1'b1;
            default:  o_cmd        = '0;
        endcase
    end

endmodule

// ===== hw/rtl/sse_dp.sv =====
// Datapath of the sprite scanline evaluator: attribute memory, range compare,
// pending result and output register. Depends on sse_pkg; driven by sse_ctrl.
module sse_dp
    import sse_pkg::*;
#(
    parameter int SPRITE_ENTRIES = DEF_SPRITE_ENTRIES,
    parameter int SLOTS          = DEF_SLOTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  t_in_data             i_s_data,
    input  logic                 i_m_ready,
    output logic                 o_m_valid,
    output t_result              o_m_result
);

    localparam int MROW_W = $clog2(SPRITE_ENTRIES);
    localparam int ENT_W  = $clog2(SPRITE_ENTRIES + 1);
    localparam int KEPT_W = $clog2(SLOTS + 1);
    localparam int WROW_W = BYTE_W - LANE_W;

    logic [BYTE_W-1:0] r_mem [LANES][SPRITE_ENTRIES];
    logic [BYTE_W-1:0] r_rd  [LANES];

    logic              r_tall;
    logic              r_tbl;
    logic [BYTE_W-1:0] r_line;
    logic [ENT_W-1:0]  r_entry;
    logic              r_ev_vld;
    logic              r_ev_zero;
    logic [KEPT_W-1:0] r_kept;
    logic              r_ovf;
    logic              r_zero;
    logic              r_pend_vld;
    t_result           r_pend;
    logic              r_out_vld;
    t_result           r_out;

    logic [LANES-1:0]  w_we;
    logic [MROW_W-1:0] w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic [WROW_W-1:0] w_wrow;
    logic              w_wrow_ok;
    logic              w_re;
    logic              w_more;

    logic [BYTE_W:0]   w_diff;
    logic              w_hit;
    logic [ROW_W-1:0]  w_row;
    logic [ADDR_W-1:0] w_addr;
    t_result           w_new;
    logic              w_room;
    logic              w_keep;
    logic              w_can_out;
    logic              w_stall;
    logic              w_adv;
    logic              w_push_mid;
    logic              w_push_fin;
    t_result           w_fin;

    // memory write: clear sweep or byte write
    assign w_wrow    = i_s_data.mem_address[BYTE_W-1:LANE_W];
    assign w_wrow_ok = {1'b0, w_wrow} < (WROW_W + 1)'(SPRITE_ENTRIES);
    assign w_waddr   = i_cmd.clear ? r_entry[MROW_W-1:0] : w_wrow[MROW_W-1:0];
    assign w_wdata   = i_cmd.clear ? '0 : i_s_data.mem_data;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_we[l] = i_cmd.clear || (i_cmd.wr && w_wrow_ok
                      && i_s_data.mem_address[LANE_W-1:0] == LANE_W'(l));
        end
    end

    assign w_more = r_entry < ENT_W'(SPRITE_ENTRIES);
    assign w_re   = w_adv && w_more;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (w_we[l]) r_mem[l][w_waddr] <= w_wdata;
            if (w_re) r_rd[l] <= r_mem[l][r_entry[MROW_W-1:0]];
        end
    end

    // range test and result fields of the entry under evaluation
    assign w_diff = {1'b0, r_line} - {1'b0, r_rd[LANE_Y]};
    assign w_hit  = !w_diff[BYTE_W] && (r_tall ? w_diff[BYTE_W-1:4] == '0
                                               : w_diff[BYTE_W-1:3] == '0);

    always_comb begin
        w_row = w_diff[ROW_W-1:0];
        if (r_rd[LANE_ATTR][ATTR_VFLIP_BIT]) begin
            w_row = r_tall ? ~w_diff[ROW_W-1:0] : {1'b0, ~w_diff[2:0]};
        end
        if (r_tall) begin
            w_addr = {r_rd[LANE_TILE][0], r_rd[LANE_TILE][BYTE_W-1:1], w_row[3],
                      1'b0, w_row[2:0]};
        end else begin
            w_addr = {r_tbl, r_rd[LANE_TILE], 1'b0, w_row[2:0]};
        end
    end

    always_comb begin
        w_new       = '0;
        w_new.found = 1'b1;
        w_new.slot  = SLOT_W'(r_kept);
        w_new.tile  = r_rd[LANE_TILE];
        w_new.attr  = r_rd[LANE_ATTR];
        w_new.x_pos = r_rd[LANE_X];
        w_new.row   = w_row;
        w_new.addr  = w_addr;
    end

    assign w_room     = r_kept < KEPT_W'(SLOTS);
    assign w_keep     = i_cmd.scan && r_ev_vld && w_hit && w_room;
    assign w_can_out  = !r_out_vld || i_m_ready;
    assign w_stall    = w_keep && r_pend_vld && !w_can_out;
    assign w_adv      = i_cmd.scan && !w_stall;
    assign w_push_mid = w_keep && r_pend_vld && w_can_out;
    assign w_push_fin = i_cmd.finish && w_can_out;

    always_comb begin
        w_fin          = r_pend_vld ? r_pend : '0;
        w_fin.count    = COUNT_W'(r_kept);
        w_fin.overflow = r_ovf;
        w_fin.zero_hit = r_zero;
        w_fin.last     = 1'b1;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tall     <= 1'b0;
            r_tbl      <= 1'b0;
            r_entry    <= '0;
            r_ev_vld   <= 1'b0;
            r_kept     <= '0;
            r_ovf      <= 1'b0;
            r_zero     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TALL) r_tall <= i_cfg_data;
                if (i_cfg_index == CFG_TABLE_HIGH) r_tbl <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_entry <= r_entry + 1'b1;
            end
            if (i_cmd.start) begin
                r_entry    <= '0;
                r_ev_vld   <= 1'b0;
                r_kept     <= '0;
                r_ovf      <= 1'b0;
                r_zero     <= 1'b0;
                r_pend_vld <= 1'b0;
            end
            if (w_adv) begin
                r_ev_vld <= w_more;
                if (w_more) r_entry <= r_entry + 1'b1;
                if (r_ev_vld && w_hit) begin
                    if (w_room) begin
                        r_pend_vld <= 1'b1;
                        r_kept     <= r_kept + 1'b1;
                        if (r_ev_zero) r_zero <= 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (w_push_mid || w_push_fin) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_line <= i_s_data.scanline;
        if (w_re) r_ev_zero <= r_entry == '0;
        if (w_adv && w_keep) r_pend <= w_new;
        if (w_push_mid) begin
            r_out <= r_pend;
        end else if (w_push_fin) begin
            r_out <= w_fin;
        end
    end

    assign o_stat.clear_done = i_cmd.clear && r_entry == ENT_W'(SPRITE_ENTRIES - 1);
    assign o_stat.scan_done  = !w_more && !r_ev_vld;
    assign o_stat.final_done = w_push_fin;
    assign o_m_valid         = r_out_vld;
    assign o_m_result        = r_out;

endmodule

// ===== hw/rtl/sprite_scanline_evaluator.sv =====
// Write item: one per cycle while idle. Evaluate item: one attribute entry read and compared
// per cycle while the scan does not stall; the next item is taken once the final result has
// entered the output register. Kept sprites leave while the scan goes on and a full output
// register stalls the scan. One item in work at a time.
// Reset: synchronous; then a clearing pass over every entry zeroes the attribute
// memory with o_s_axis_tready low (configuration writes are taken throughout).
module sprite_scanline_evaluator
    import sse_pkg::*;
#(
    parameter int SPRITE_ENTRIES = DEF_SPRITE_ENTRIES,
    parameter int SLOTS          = DEF_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] mem_address, [15:8] mem_data, [23:16] scanline
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] op
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] slot, [10:3] tile_number, [18:11] attributes, [26:19] x_position,
    // [30:27] row_in_sprite, [43:31] pattern_address, [47:44] sprite_count,
    // [48] overflow, [49] sprite_zero_hit_range, [55:50] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] sprite_found
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_res;

    sse_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_op    (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (w_cmd),
        .i_stat    (w_stat)
    );

    sse_dp #(
        .SPRITE_ENTRIES (SPRITE_ENTRIES),
        .SLOTS          (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_data    (t_in_data'(i_s_axis_tdata)),
        .i_m_ready   (i_m_axis_tready),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_result  (w_res)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_res.zero_hit, w_res.overflow, w_res.count,
                             w_res.addr, w_res.row, w_res.x_pos, w_res.attr, w_res.tile,
                             w_res.slot};
    assign o_m_axis_tuser = w_res.found;
    assign o_m_axis_tlast = w_res.last;

endmodule

// ===== hw/rtl/sse_checker.sv =====
// Port-level checker for the sprite scanline evaluator, with its bind.
// Depends on sse_pkg and sprite_scanline_evaluator_macros.svh.
`include "sprite_scanline_evaluator_macros.svh"

module sse_checker
    import sse_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  i_s_tready,
    input logic                  i_s_tuser,
    input logic                  i_m_tvalid,
    input logic [OUT_DATA_W-1:0] i_m_tdata,
    input logic                  i_m_tuser,
    input logic                  i_m_tlast
);

    `SSE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tuser == OP_EVAL, !i_s_tready, "intake open right after an evaluate item")
    `SSE_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tuser == OP_WRITE, i_s_tready, "intake closed after a write item")
    `SSE_ASSERT_SAME(a_mid_found, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, i_m_tuser, "non-final item without a sprite")
    `SSE_ASSERT_SAME(a_mid_summary, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, i_m_tdata[49:44] == '0, "summary set on a non-final item")
    `SSE_ASSERT_SAME(a_empty_item, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser, i_m_tlast && i_m_tdata[47:0] == '0, "empty item not final or not zero")

endmodule

bind sprite_scanline_evaluator sse_checker u_sse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tuser  (i_s_axis_tuser),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);
